>>> sv/bdlp_pkg.sv
// Shared constants and types for the button debounce and long-press unit.
package bdlp_pkg;

  localparam int unsigned Buttons    = 4;
  localparam int unsigned BtnIdxW    = 2;
  localparam int unsigned MaskW      = 4;
  localparam int unsigned TickW      = 8;
  localparam logic [TickW-1:0] LongHoldReset = TickW'(12);

  typedef logic [Buttons-1:0] btn_vec_t;
  typedef logic [TickW-1:0]   tick_t;

endpackage

>>> sv/button_debounce_long_press_unit.sv
// Top level of the button debounce and long-press unit.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------------
//   request  | in_valid_i / in_ready_o | kind_i, button_i, levels_i
//   result   | out_valid_o/out_ready_i | short_press_o, long_press_o, edge_armed_o,
//            |                         | timer_running_o
//   config   | cfg_we_i                | cfg_data_i (long_hold_ticks)
//
// One request per cycle while the result side is not stalled; its result appears in the cycle after acceptance.
// Button state updates at acceptance; the result register holds the outcome.
// in_ready_o is high while the result register is empty or being drained.
// A stall on the result side holds the result and blocks new requests.
// Reset: all buttons armed, nothing pending or held, timer stopped, limit 12.
module button_debounce_long_press_unit
  import bdlp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [BtnIdxW-1:0] button_i,
  input  logic [MaskW-1:0]   levels_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [MaskW-1:0]   short_press_o,
  output logic [MaskW-1:0]   long_press_o,
  output logic [MaskW-1:0]   edge_armed_o,
  output logic               timer_running_o,
  input  logic               cfg_we_i,
  input  logic [TickW-1:0]   cfg_data_i
);

  tick_t    limit_q;
  btn_vec_t pending_q, pending_d;
  btn_vec_t held_q, held_d;
  btn_vec_t armed_q, armed_d;
  logic     running_q, running_d;
  tick_t    count_q [Buttons];
  tick_t    count_d [Buttons];

  btn_vec_t shorts_d, longs_d, restart, pressed, edge_bit;
  logic     accept;
  logic [MaskW+Buttons-1:0] lvl_ext;

  logic             out_valid_q;
  logic [MaskW-1:0] short_q, long_q, armed_out_q;
  logic             run_out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Buttons without a level bit read as released.
  assign lvl_ext  = {{Buttons{1'b1}}, levels_i};
  assign pressed  = ~lvl_ext[Buttons-1:0];
  assign edge_bit = btn_vec_t'(1) << button_i;

  always_comb begin
    pending_d = pending_q;
    held_d    = held_q;
    armed_d   = armed_q;
    running_d = running_q;
    shorts_d  = '0;
    longs_d   = '0;
    restart   = '0;
    for (int i = 0; i < Buttons; i++) begin
      count_d[i] = count_q[i];
    end
    if (!kind_i) begin
      if (|(edge_bit & armed_q)) begin
        armed_d   = armed_q & ~edge_bit;
        pending_d = pending_q | edge_bit;
        running_d = 1'b1;
      end
    end else if (running_q) begin
      for (int i = 0; i < Buttons; i++) begin
        if (pending_q[i]) begin
          pending_d[i] = 1'b0;
          if (pressed[i]) begin
            held_d[i]  = 1'b1;
            restart[i] = 1'b1;
          end else begin
            armed_d[i] = 1'b1;
          end
        end else if (held_q[i]) begin
          if (pressed[i]) begin
            if (count_q[i] < limit_q) begin
              count_d[i] = count_q[i] + tick_t'(1);
            end
            restart[i] = 1'b1;
          end else begin
            if (count_q[i] >= limit_q) begin
              longs_d[i] = 1'b1;
            end else begin
              shorts_d[i] = 1'b1;
            end
            held_d[i]  = 1'b0;
            count_d[i] = '0;
            armed_d[i] = 1'b1;
          end
        end
      end
      running_d = |restart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LongHoldReset;
      pending_q   <= '0;
      held_q      <= '0;
      armed_q     <= '1;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Buttons; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (accept) begin
        pending_q   <= pending_d;
        held_q      <= held_d;
        armed_q     <= armed_d;
        running_q   <= running_d;
        out_valid_q <= 1'b1;
        for (int i = 0; i < Buttons; i++) begin
          count_q[i] <= count_d[i];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register: payload only, no reset.
  logic [MaskW+Buttons-1:0] short_ext, long_ext, armed_ext;
  assign short_ext = {{MaskW{1'b0}}, shorts_d};
  assign long_ext  = {{MaskW{1'b0}}, longs_d};
  assign armed_ext = {{MaskW{1'b0}}, armed_d};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      short_q     <= short_ext[MaskW-1:0];
      long_q      <= long_ext[MaskW-1:0];
      armed_out_q <= armed_ext[MaskW-1:0];
      run_out_q   <= running_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign short_press_o   = short_q;
  assign long_press_o    = long_q;
  assign edge_armed_o    = armed_out_q;
  assign timer_running_o = run_out_q;

endmodule

>>> sv/bdlp_checker.sv
// Port-level checker for the button debounce and long-press unit, with its bind.
module bdlp_checker
  import bdlp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [MaskW-1:0]   short_press_o,
  input  logic [MaskW-1:0]   long_press_o,
  input  logic [MaskW-1:0]   edge_armed_o,
  input  logic               timer_running_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(short_press_o)
      && $stable(long_press_o) && $stable(edge_armed_o) && $stable(timer_running_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("request side blocked while result side drains");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (short_press_o & long_press_o) == '0)
    else $error("button reported as both short and long press");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((short_press_o | long_press_o) & ~edge_armed_o) == '0)
    else $error("released button not re-armed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request produced no result");

endmodule

bind button_debounce_long_press_unit bdlp_checker u_bdlp_checker (.*);
